FILE: design/fls_pkg.sv
// Package: SHA-512 constants, round functions and command codes.
package fls_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_ABSORB = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned PadLimit   = 112;
  localparam int unsigned Rounds     = 80;
  localparam logic [3:0]  LenWord    = 4'(PadLimit / 8);

  typedef logic [63:0] word_t;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic word_t round_const(input logic [6:0] i);
    word_t r;
    case (i)
      7'd0: r = 64'h428a2f98d728ae22;   7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f;   7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538;   7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b;   7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242;   7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c;  7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f;  7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235;  7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2;  7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5;  7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275;  7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4;  7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab;  7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f;  7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2;  7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f;  7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc;  7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed;  7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de;  7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6;  7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364;  7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791;  7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218;  7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a;  7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8;  7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99;  7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63;  7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373;  7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc;  7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72;  7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28;  7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915;  7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c;  7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e;  7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba;  7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae;  7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84;  7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc;  7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6;  7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec;  default: r = 64'h6c44198c4a475817;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  typedef struct packed {
    logic       start;
    logic [6:0] round;
  } rnd_ctl_t;

endpackage

FILE: design/four_lane_sha512_hasher_unit.sv
// Top level: four-lane SHA-512 hasher with command sequencer and round units.
// Start and load are taken while idle and leave the block ready for the next command. An absorb
// of n bytes (n is capped at eight) keeps the block busy while the bytes move into the buffer,
// and for every block that fills, while the round units load it and run the rounds, one round
// per cycle in each lane's round unit. A finish pads the buffer, compresses it first when 112 or
// more bytes are buffered, places the length, compresses the last block, then gives the
// eight digest transactions, one per cycle while the output is not stalled. Only one
// transaction is in work at a time.
module four_lane_sha512_hasher_unit #(
  parameter int unsigned LANE_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  word_index_i,
  input  logic [63:0] lane0_data_i,
  input  logic [63:0] lane1_data_i,
  input  logic [63:0] lane2_data_i,
  input  logic [63:0] lane3_data_i,
  input  logic [3:0]  byte_count_i,
  input  logic [63:0] prior_length_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  digest_index_o,
  output logic [63:0] digest_lane0_o,
  output logic [63:0] digest_lane1_o,
  output logic [63:0] digest_lane2_o,
  output logic [63:0] digest_lane3_o,
  output logic        last_word_o
);
  import fls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ABS, S_PAD, S_LEN, S_LDR, S_RND, S_OUT
  } state_e;

  state_e      state_q;
  logic [6:0]  fill_q;
  logic [63:0] len_q;
  logic [3:0]  bcnt_q, bidx_q;
  logic [63:0] dat_q [LANE_COUNT];
  logic [6:0]  rnd_q;
  logic        fin_q, final_q;
  logic [2:0]  oidx_q;
  logic        ovld_q;
  word_t       cv_q [LANE_COUNT][8];
  word_t       buf_q [LANE_COUNT][16];
  word_t       vout [LANE_COUNT][8];
  word_t       pad_keep, pad_mark;
  rnd_ctl_t    ctl;
  logic        step;

  assign pad_keep = ~(64'hffff_ffff_ffff_ffff >> {fill_q[2:0], 3'b000});
  assign pad_mark = 64'h8000_0000_0000_0000 >> {fill_q[2:0], 3'b000};

  assign ctl.start = (state_q == S_LDR);
  assign ctl.round = rnd_q;
  assign step = (state_q == S_RND) && (rnd_q != 7'(Rounds));

  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    fls_round u_round (
      .clk_i(clk_i), .ctl_i(ctl), .step_i(step),
      .blk_i(buf_q[l]), .cv_i(cv_q[l]), .v_o(vout[l])
    );
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ovld_q;
  assign digest_index_o = oidx_q;
  assign last_word_o = (oidx_q == 3'd7);
  assign digest_lane0_o = cv_q[0][oidx_q];
  assign digest_lane1_o = (LANE_COUNT > 1) ? cv_q[(LANE_COUNT > 1) ? 1 : 0][oidx_q] : '0;
  assign digest_lane2_o = (LANE_COUNT > 2) ? cv_q[(LANE_COUNT > 2) ? 2 : 0][oidx_q] : '0;
  assign digest_lane3_o = (LANE_COUNT > 3) ? cv_q[(LANE_COUNT > 3) ? 3 : 0][oidx_q] : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && command_i == CMD_ABSORB) begin
      dat_q[0] <= lane0_data_i;
      if (LANE_COUNT > 1) dat_q[(LANE_COUNT > 1) ? 1 : 0] <= lane1_data_i;
      if (LANE_COUNT > 2) dat_q[(LANE_COUNT > 2) ? 2 : 0] <= lane2_data_i;
      if (LANE_COUNT > 3) dat_q[(LANE_COUNT > 3) ? 3 : 0] <= lane3_data_i;
      for (int l = 4; l < LANE_COUNT; l++) dat_q[l] <= lane0_data_i;
    end
    for (int l = 0; l < LANE_COUNT; l++) begin
      if (state_q == S_ABS && bidx_q != bcnt_q)
        buf_q[l][fill_q[6:3]][63 - 8*fill_q[2:0] -: 8] <= dat_q[l][63 - 8*bidx_q[2:0] -: 8];
      if (state_q == S_PAD)
        for (int i = 0; i < 16; i++) begin
          if (4'(i) == fill_q[6:3]) buf_q[l][i] <= (buf_q[l][i] & pad_keep) | pad_mark;
          else if (4'(i) > fill_q[6:3]) buf_q[l][i] <= '0;
        end
      if (state_q == S_LEN) begin
        if (fin_q)
          for (int i = 0; i < int'(LenWord); i++) buf_q[l][i] <= '0;
        buf_q[l][LenWord] <= '0;
        buf_q[l][LenWord + 4'd1] <= len_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fill_q <= '0; len_q <= '0; bcnt_q <= '0; bidx_q <= '0;
      rnd_q <= '0; fin_q <= 1'b0; final_q <= 1'b0; oidx_q <= '0; ovld_q <= 1'b0;
      for (int l = 0; l < LANE_COUNT; l++)
        for (int i = 0; i < 8; i++) cv_q[l][i] <= init_word(3'(i));
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (command_i)
              CMD_START: begin
                for (int l = 0; l < LANE_COUNT; l++)
                  for (int i = 0; i < 8; i++) cv_q[l][i] <= init_word(3'(i));
                fill_q <= '0; len_q <= '0;
              end
              CMD_LOAD: begin
                for (int l = 0; l < LANE_COUNT; l++) cv_q[l][word_index_i] <= lane0_data_i;
                fill_q <= '0;
                if (word_index_i == 3'd0) len_q <= prior_length_bits_i;
              end
              CMD_ABSORB: begin
                bcnt_q <= (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
                bidx_q <= '0;
                state_q <= S_ABS;
              end
              CMD_FINISH: begin
                len_q <= len_q + {54'd0, fill_q, 3'd0};
                state_q <= S_PAD;
              end
            endcase
          end
        end
        S_ABS: begin
          if (bidx_q == bcnt_q) state_q <= S_IDLE;
          else begin
            bidx_q <= bidx_q + 4'd1;
            if (fill_q == 7'(BlockBytes - 1)) begin
              fill_q <= '0; len_q <= len_q + 64'd1024;
              final_q <= 1'b0; state_q <= S_LDR;
            end else fill_q <= fill_q + 7'd1;
          end
        end
        S_PAD: begin
          if (fill_q >= 7'(PadLimit)) begin
            fin_q <= 1'b1; final_q <= 1'b0; state_q <= S_LDR;
          end else state_q <= S_LEN;
        end
        S_LEN: begin
          fin_q <= 1'b0; final_q <= 1'b1; state_q <= S_LDR;
        end
        S_LDR: begin
          rnd_q <= '0; state_q <= S_RND;
        end
        S_RND: begin
          if (rnd_q == 7'(Rounds)) begin
            for (int l = 0; l < LANE_COUNT; l++)
              for (int i = 0; i < 8; i++) cv_q[l][i] <= cv_q[l][i] + vout[l][i];
            if (final_q) begin
              oidx_q <= '0; ovld_q <= 1'b1; state_q <= S_OUT;
            end else if (fin_q) state_q <= S_LEN;
            else state_q <= S_ABS;
          end else rnd_q <= rnd_q + 7'd1;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              ovld_q <= 1'b0; state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/fls_round.sv
// One lane's SHA-512 round unit with a sixteen-word rolling schedule window.
module fls_round (
  input  logic               clk_i,
  input  fls_pkg::rnd_ctl_t  ctl_i,
  input  logic               step_i,
  input  fls_pkg::word_t     blk_i [16],
  input  fls_pkg::word_t     cv_i [8],
  output fls_pkg::word_t     v_o [8]
);
  import fls_pkg::*;

  word_t w_q [16];
  word_t v_q [8];
  word_t s0, s1, wnew, t1, t2;

  always_comb begin
    s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
    s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_const(ctl_i.round) + w_q[0];
    t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      w_q <= blk_i;
      v_q <= cv_i;
    end else if (step_i) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign v_o = v_q;
endmodule

FILE: verif/four_lane_sha512_hasher_unit_tb.sv
// Self-checking testbench for the four-lane SHA-512 hasher with a built-in digest predictor.
`timescale 1ns / 100ps
module four_lane_sha512_hasher_unit_tb;
  import fls_pkg::*;

  localparam int unsigned Lanes = 4;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [2:0]  idx;
    logic [63:0] d0;
    logic [63:0] d1;
    logic [63:0] d2;
    logic [63:0] d3;
    logic        last;
  } digest_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [2:0]  word_index_i;
  logic [63:0] lane0_data_i;
  logic [63:0] lane1_data_i;
  logic [63:0] lane2_data_i;
  logic [63:0] lane3_data_i;
  logic [3:0]  byte_count_i;
  logic [63:0] prior_length_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  digest_index_o;
  logic [63:0] digest_lane0_o;
  logic [63:0] digest_lane1_o;
  logic [63:0] digest_lane2_o;
  logic [63:0] digest_lane3_o;
  logic        last_word_o;

  four_lane_sha512_hasher_unit uut (.*);

  logic [63:0] hash_state [Lanes][8];
  logic [7:0]  msg_block [Lanes][128];
  int unsigned buffered;
  logic [63:0] bit_total;
  digest_word_t pending_digests [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          stall_enable;

  const logic [63:0] round_k [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  const logic [63:0] iv_words [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_lanes();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int l = 0; l < Lanes; l++) begin
      for (int i = 0; i < 16; i++) begin
        w[i] = '0;
        for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], msg_block[l][i*8+j]};
      end
      for (int i = 16; i < 80; i++)
        w[i] = w[i-16] + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7))
             + w[i-7] + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
      for (int i = 0; i < 8; i++) v[i] = hash_state[l][i];
      for (int i = 0; i < 80; i++) begin
        t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[i] + w[i];
        t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[l][i] += v[i];
    end
  endtask

  task automatic predict_digest(cmd_e cmd, logic [2:0] widx, logic [63:0] d [4],
                                logic [3:0] cnt, logic [63:0] prior);
    int unsigned n;
    digest_word_t dw;
    case (cmd)
      CMD_START: begin
        for (int l = 0; l < Lanes; l++)
          for (int i = 0; i < 8; i++) hash_state[l][i] = iv_words[i];
        buffered = 0;
        bit_total = '0;
      end
      CMD_LOAD: begin
        for (int l = 0; l < Lanes; l++) hash_state[l][widx] = d[0];
        buffered = 0;
        if (widx == 3'd0) bit_total = prior;
      end
      CMD_ABSORB: begin
        n = (cnt > 8) ? 8 : cnt;
        for (int b = 0; b < n; b++) begin
          for (int l = 0; l < Lanes; l++) msg_block[l][buffered] = d[l][63-8*b -: 8];
          buffered++;
          if (buffered >= BlockBytes) begin
            compress_lanes();
            bit_total += 64'd1024;
            buffered = 0;
          end
        end
      end
      default: begin
        for (int l = 0; l < Lanes; l++) begin
          msg_block[l][buffered] = 8'h80;
          for (int b = buffered + 1; b < BlockBytes; b++) msg_block[l][b] = 8'h00;
        end
        if (buffered >= PadLimit) begin
          compress_lanes();
          for (int l = 0; l < Lanes; l++)
            for (int b = 0; b < BlockBytes; b++) msg_block[l][b] = 8'h00;
        end
        bit_total += 64'(buffered) * 64'd8;
        for (int l = 0; l < Lanes; l++)
          for (int b = 0; b < 8; b++) begin
            msg_block[l][PadLimit+b] = 8'h00;
            msg_block[l][120+b] = bit_total[63-8*b -: 8];
          end
        compress_lanes();
        for (int k = 0; k < 8; k++) begin
          dw.idx = 3'(k);
          dw.d0 = hash_state[0][k];
          dw.d1 = hash_state[1][k];
          dw.d2 = hash_state[2][k];
          dw.d3 = hash_state[3][k];
          dw.last = (k == 7);
          pending_digests.push_back(dw);
        end
      end
    endcase
  endtask

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_command(cmd_e cmd, logic [2:0] widx, logic [63:0] d0, logic [63:0] d1,
                              logic [63:0] d2, logic [63:0] d3, logic [3:0] cnt,
                              logic [63:0] prior);
    logic [63:0] d [4];
    int unsigned gap;
    d = '{d0, d1, d2, d3};
    gap = random_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    word_index_i <= widx;
    lane0_data_i <= d0;
    lane1_data_i <= d1;
    lane2_data_i <= d2;
    lane3_data_i <= d3;
    byte_count_i <= cnt;
    prior_length_bits_i <= prior;
    predict_digest(cmd, widx, d, cnt, prior);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_absorb(logic [3:0] cnt);
    send_command(CMD_ABSORB, 3'($urandom()), rand64(), rand64(), rand64(), rand64(), cnt,
                 rand64());
  endtask

  task automatic send_simple(cmd_e cmd);
    send_command(cmd, 3'($urandom()), rand64(), rand64(), rand64(), rand64(),
                 4'($urandom()), rand64());
  endtask

  task automatic wait_drained();
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_simple(CMD_FINISH);
    send_simple(CMD_START);
    send_command(CMD_ABSORB, 3'd0, '1, '1, '1, '1, 4'd8, '0);
    send_command(CMD_ABSORB, 3'd7, '0, '0, '0, '0, 4'd1, '1);
    send_command(CMD_ABSORB, 3'd0, rand64(), rand64(), rand64(), rand64(), 4'd0, '0);
    send_command(CMD_ABSORB, 3'd0, rand64(), rand64(), rand64(), rand64(), 4'd15, '0);
    send_simple(CMD_FINISH);
    send_simple(CMD_FINISH);
    send_simple(CMD_START);
    for (int i = 0; i < 14; i++) send_absorb(4'd8);
    send_simple(CMD_FINISH);
    for (int i = 0; i < 8; i++)
      send_command(CMD_LOAD, 3'(7 - i), (i == 7) ? '1 : rand64(), '1, '1, '1, '0,
                   64'hffff_ffff_ffff_fc00);
    for (int i = 0; i < 2; i++) send_absorb(4'd8);
    send_simple(CMD_FINISH);
  endtask

  task automatic test_random_messages();
    int unsigned items;
    int unsigned len;
    items = 0;
    while (items < 300) begin
      if ($urandom_range(0, 9) == 0) begin
        send_simple(cmd_e'($urandom_range(0, 3)));
        items++;
      end else begin
        if ($urandom_range(0, 1)) send_simple(CMD_START);
        else begin
          for (int w = 7; w >= 0; w--)
            send_command(CMD_LOAD, 3'(w), rand64(), rand64(), rand64(), rand64(), '0,
                         ($urandom_range(0, 3) == 0) ? ~64'(($urandom_range(0, 8)) * 1024)
                                                     : rand64());
          items += 7;
        end
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++) send_absorb(4'($urandom_range(0, 15)));
        send_simple(CMD_FINISH);
        items += len + 2;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned stall_len;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        stall_len = random_gap();
        if (stall_len > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    digest_word_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected digest transaction %0d", digest_index_o);
      end else begin
        want = pending_digests.pop_front();
        if (want !== {digest_index_o, digest_lane0_o, digest_lane1_o, digest_lane2_o,
                      digest_lane3_o, last_word_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d %h %h %h %h %b, got %0d %h %h %h %h %b",
                     want.idx, want.d0, want.d1, want.d2, want.d3, want.last,
                     digest_index_o, digest_lane0_o, digest_lane1_o, digest_lane2_o,
                     digest_lane3_o, last_word_o);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    stall_enable = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_START;
    word_index_i = '0;
    lane0_data_i = '0;
    lane1_data_i = '0;
    lane2_data_i = '0;
    lane3_data_i = '0;
    byte_count_i = '0;
    prior_length_bits_i = '0;
    for (int l = 0; l < Lanes; l++) begin
      for (int i = 0; i < 8; i++) hash_state[l][i] = iv_words[i];
      for (int b = 0; b < 128; b++) msg_block[l][b] = '0;
    end
    buffered = 0;
    bit_total = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    stall_enable = 1'b1;
    test_random_messages();
    in_valid_i <= 1'b0;
    wait_drained();
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
